>>> rtl/thin3d_voxel_deletable_test_unit_macros.svh
// assertion macros for the voxel deletable test unit
`ifndef THIN3D_VOXEL_DELETABLE_TEST_UNIT_MACROS_SVH
`define THIN3D_VOXEL_DELETABLE_TEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define T3VDT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define T3VDT_NEVER(lbl, cond, msg) \
    `T3VDT_ASSERT(lbl, !(cond), msg)
`else
`define T3VDT_ASSERT(lbl, prop, msg)
`define T3VDT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/t3vdt_pkg.sv
// shared constants, tables and types for the voxel deletable test unit
`timescale 1ns / 1ps
`default_nettype none
package t3vdt_pkg;

    localparam int NB_COUNT  = 26;
    localparam int OCT_COUNT = 8;
    localparam int OCT_SIZE  = 7;
    localparam int CNT_W     = 5;
    localparam int EUL_W     = 7;

    // neighbour indices per octant, position j drives code bit (6 - j)
    localparam logic [4:0] OCT_MEMBERS [OCT_COUNT][OCT_SIZE] = '{
        '{5'd23, 5'd24, 5'd14, 5'd15, 5'd20, 5'd21, 5'd12},
        '{5'd25, 5'd22, 5'd16, 5'd13, 5'd24, 5'd21, 5'd15},
        '{5'd17, 5'd20, 5'd9,  5'd12, 5'd18, 5'd21, 5'd10},
        '{5'd19, 5'd22, 5'd18, 5'd21, 5'd11, 5'd13, 5'd10},
        '{5'd6,  5'd14, 5'd7,  5'd15, 5'd3,  5'd12, 5'd4},
        '{5'd8,  5'd7,  5'd16, 5'd15, 5'd5,  5'd4,  5'd13},
        '{5'd0,  5'd9,  5'd3,  5'd12, 5'd1,  5'd10, 5'd4},
        '{5'd2,  5'd1,  5'd11, 5'd10, 5'd5,  5'd4,  5'd13}
    };

    localparam logic signed [3:0] EULER_LUT [128] = '{
         1, -1, -1,  1, -3, -1, -1,  1, -1,  1,  1, -1,  3,  1,  1, -1,
        -3, -1,  3,  1,  1, -1,  3,  1, -1,  1,  1, -1,  3,  1,  1, -1,
        -3,  3, -1,  1,  1,  3, -1,  1, -1,  1,  1, -1,  3,  1,  1, -1,
         1,  3,  3,  1,  5,  3,  3,  1, -1,  1,  1, -1,  3,  1,  1, -1,
        -7, -1, -1,  1, -3, -1, -1,  1, -1,  1,  1, -1,  3,  1,  1, -1,
        -3, -1,  3,  1,  1, -1,  3,  1, -1,  1,  1, -1,  3,  1,  1, -1,
        -3,  3, -1,  1,  1,  3, -1,  1, -1,  1,  1, -1,  3,  1,  1, -1,
         1,  3,  3,  1,  5,  3,  3,  1, -1,  1,  1, -1,  3,  1,  1, -1
    };

    typedef enum logic [2:0] {
        RSN_PASS       = 3'd0,
        RSN_CENTER_OFF = 3'd1,
        RSN_FACE_ON    = 3'd2,
        RSN_ENDPOINT   = 3'd3,
        RSN_EULER      = 3'd4,
        RSN_NOT_SIMPLE = 3'd5
    } t_reason;

    typedef logic [OCT_COUNT-1:0][OCT_COUNT-1:0] t_adj;

    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic                 face_fail;
        logic                 euler_zero;
        logic [OCT_COUNT-1:0] active;
        logic [OCT_COUNT-1:0] start;
        t_adj                 adj;
    } t_front_info;

    function automatic logic [NB_COUNT-1:0] oct_mask(input int k);
        logic [NB_COUNT-1:0] m;
        m = '0;
        for (int j = 0; j < OCT_SIZE; j++) begin
            m[OCT_MEMBERS[k][j]] = 1'b1;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> rtl/t3vdt_front.sv
// first stage logic: count, face check, euler sum and octant adjacency
`timescale 1ns / 1ps
`default_nettype none
module t3vdt_front (
    input  wire logic [t3vdt_pkg::NB_COUNT-1:0] i_nb,
    input  wire logic [2:0]                     i_dir,
    output t3vdt_pkg::t_front_info              o_info
);
    import t3vdt_pkg::*;

    logic [CNT_W-1:0]          cnt;
    logic signed [EUL_W-1:0]   esum;
    logic [6:0]                code;
    logic [3:0]                eval;
    logic                      face;
    logic [OCT_COUNT-1:0]      act;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < NB_COUNT; i++) begin
            cnt = cnt + CNT_W'(i_nb[i]);
        end

        esum = '0;
        for (int k = 0; k < OCT_COUNT; k++) begin
            for (int j = 0; j < OCT_SIZE; j++) begin
                code[6-j] = i_nb[OCT_MEMBERS[k][j]];
            end
            eval = EULER_LUT[code];
            esum = esum + {{(EUL_W-4){eval[3]}}, eval};
        end

        unique case (i_dir)
            3'd0:    face = i_nb[10];
            3'd1:    face = i_nb[15];
            3'd2:    face = i_nb[13];
            3'd3:    face = i_nb[12];
            3'd4:    face = i_nb[21];
            3'd5:    face = i_nb[4];
            default: face = 1'b1;   // no face selected counts as a failure
        endcase

        for (int k = 0; k < OCT_COUNT; k++) begin
            act[k] = |(i_nb & oct_mask(k));
            for (int l = 0; l < OCT_COUNT; l++) begin
                o_info.adj[k][l] = |(i_nb & oct_mask(k) & oct_mask(l));
            end
        end

        o_info.count      = cnt;
        o_info.face_fail  = face;
        o_info.euler_zero = (esum == '0);
        o_info.active     = act;
        o_info.start      = act & (~act + OCT_COUNT'(1));
    end
endmodule
`default_nettype wire

>>> rtl/t3vdt_conn.sv
// four rounds of reach propagation over the octant adjacency graph
`timescale 1ns / 1ps
`default_nettype none
module t3vdt_conn (
    input  wire logic [t3vdt_pkg::OCT_COUNT-1:0] i_reach,
    input  wire t3vdt_pkg::t_adj                 i_adj,
    output logic [t3vdt_pkg::OCT_COUNT-1:0]      o_reach
);
    import t3vdt_pkg::*;

    localparam int ROUNDS = 4;

    logic [OCT_COUNT-1:0] r;
    logic [OCT_COUNT-1:0] nx;

    always_comb begin
        r = i_reach;
        for (int s = 0; s < ROUNDS; s++) begin
            nx = r;
            for (int k = 0; k < OCT_COUNT; k++) begin
                for (int l = 0; l < OCT_COUNT; l++) begin
                    nx[k] = nx[k] | (r[l] & i_adj[l][k]);
                end
            end
            r = nx;
        end
        o_reach = r;
    end
endmodule
`default_nettype wire

>>> rtl/thin3d_voxel_deletable_test_unit.sv
// top level of the 3d thinning voxel deletable test unit
// Usage:
//   s_axis carries one voxel neighbourhood per request. tdata holds, from
//   bit 0 up: center_on, neighbors[25:0], border_dir[2:0], zero pad to 32.
//   tuser[0] is mode (0 full candidate test, 1 simple point recheck).
//   m_axis returns one result per request. tdata holds, from bit 0 up:
//   deletable, fail_reason[2:0], neighbor_count[4:0], zero pad to 16.
//   A request passes from acceptance to the result on m_axis through four
//   registers: input register, euler / adjacency stage, first four reach
//   rounds over the octant graph, then the last four rounds and the verdict
//   into the output register. One request is taken every cycle while m_axis
//   is not stalled; throughput is one result per cycle.
//   All stages advance together whenever the output register is empty or
//   being taken, so a stall on m_axis holds the whole pipe and drops
//   s_axis_tready; nothing is lost or repeated.
//   Synchronous active low reset clears every stage valid bit; payload is
//   left as is.
`timescale 1ns / 1ps
`default_nettype none
`include "thin3d_voxel_deletable_test_unit_macros.svh"
module thin3d_voxel_deletable_test_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // center_on, neighbors[25:0], border_dir[2:0], pad
    input  wire logic [31:0] s_axis_tdata,
    // mode
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // deletable, fail_reason[2:0], neighbor_count[4:0], pad
    output logic [15:0]      m_axis_tdata
);
    import t3vdt_pkg::*;

    logic adv;

    logic r_v1, r_v2, r_v3, r_vo;

    logic                r1_mode, r1_center;
    logic [NB_COUNT-1:0] r1_nb;
    logic [2:0]          r1_dir;

    logic        r2_mode, r2_center;
    t_front_info r2_info;
    t_front_info n2_info;

    logic                 r3_mode, r3_center, r3_face_fail, r3_euler_zero;
    logic [CNT_W-1:0]     r3_count;
    logic [OCT_COUNT-1:0] r3_active;
    t_adj                 r3_adj;
    logic [OCT_COUNT-1:0] r3_reach;
    logic [OCT_COUNT-1:0] n3_reach;
    logic [OCT_COUNT-1:0] n_final_reach;

    logic             r_o_del, r_o_mode;
    t_reason          r_o_reason, n_reason;
    logic [CNT_W-1:0] r_o_count;

    assign adv = !r_vo || m_axis_tready;
    assign s_axis_tready = adv;

    t3vdt_front u_front (
        .i_nb   (r1_nb),
        .i_dir  (r1_dir),
        .o_info (n2_info)
    );

    t3vdt_conn u_conn_a (
        .i_reach (r2_info.start),
        .i_adj   (r2_info.adj),
        .o_reach (n3_reach)
    );

    t3vdt_conn u_conn_b (
        .i_reach (r3_reach),
        .i_adj   (r3_adj),
        .o_reach (n_final_reach)
    );

    always_comb begin
        if (!r3_mode) begin
            priority if (!r3_center)              n_reason = RSN_CENTER_OFF;
            else if (r3_face_fail)                n_reason = RSN_FACE_ON;
            else if (r3_count <= CNT_W'(1))       n_reason = RSN_ENDPOINT;
            else if (!r3_euler_zero)              n_reason = RSN_EULER;
            else if (n_final_reach != r3_active)  n_reason = RSN_NOT_SIMPLE;
            else                                  n_reason = RSN_PASS;
        end else begin
            priority if (r3_count == '0)          n_reason = RSN_ENDPOINT;
            else if (n_final_reach != r3_active)  n_reason = RSN_NOT_SIMPLE;
            else                                  n_reason = RSN_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_mode   <= s_axis_tuser[0];
            r1_center <= s_axis_tdata[0];
            r1_nb     <= s_axis_tdata[26:1];
            r1_dir    <= s_axis_tdata[29:27];

            r2_mode   <= r1_mode;
            r2_center <= r1_center;
            r2_info   <= n2_info;

            r3_mode       <= r2_mode;
            r3_center     <= r2_center;
            r3_face_fail  <= r2_info.face_fail;
            r3_euler_zero <= r2_info.euler_zero;
            r3_count      <= r2_info.count;
            r3_active     <= r2_info.active;
            r3_adj        <= r2_info.adj;
            r3_reach      <= n3_reach;

            r_o_mode   <= r3_mode;
            r_o_reason <= n_reason;
            r_o_del    <= (n_reason == RSN_PASS);
            r_o_count  <= r3_count;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {7'd0, r_o_count, r_o_reason, r_o_del};

    `T3VDT_ASSERT(a_del_matches_reason,
        r_vo |-> (r_o_del == (r_o_reason == RSN_PASS)), "deletable disagrees with reason")
    `T3VDT_NEVER(a_recheck_reason,
        r_vo && r_o_mode && (r_o_reason == RSN_CENTER_OFF || r_o_reason == RSN_FACE_ON
        || r_o_reason == RSN_EULER), "recheck gave a candidate-only reason")
    `T3VDT_NEVER(a_count_range, r_vo && (r_o_count > CNT_W'(NB_COUNT)), "count out of range")
    `T3VDT_NEVER(a_pass_needs_two,
        r_vo && !r_o_mode && r_o_del && (r_o_count < CNT_W'(2)), "pass with too few neighbours")
endmodule
`default_nettype wire
